FILE: hdl/stop_wait_image_chunk_receiver_assert.svh
// Assertion macros used by the checker of the chunk receiver.
`ifndef STOP_WAIT_IMAGE_CHUNK_RECEIVER_ASSERT_SVH
`define STOP_WAIT_IMAGE_CHUNK_RECEIVER_ASSERT_SVH

// Clocked property, ignored while reset is low.
`define SWICR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked property, checked during reset as well.
`define SWICR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: hdl/swicr_pkg.sv
// Package: types, constants and register map of the image chunk receiver.
package swicr_pkg;

  // Field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned POS_W   = 6;
  localparam int unsigned ADDR_W  = 4;
  localparam int unsigned DATA_W  = 32;

  // Default payload length per packet
  localparam int unsigned PAYLOAD_BYTES_DEF = 30;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_ACK = 2'd0;
  localparam logic [KIND_W-1:0] KIND_IMG = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FIN = 2'd2;

  // End-of-image marker
  localparam logic [BYTE_W-1:0] MARK_HI = 8'hFF;
  localparam logic [BYTE_W-1:0] MARK_LO = 8'hD9;

  // Register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_MAX_SEQ  = 2'd0;
  localparam logic [1:0] REG_NEW_REPS = 2'd1;
  localparam logic [1:0] REG_DUP_REPS = 2'd2;
  localparam logic [1:0] REG_FIN_REPS = 2'd3;

  // Register reset values
  localparam logic [BYTE_W-1:0] MAX_SEQ_RST  = 8'd9;
  localparam logic [BYTE_W-1:0] NEW_REPS_RST = 8'd10;
  localparam logic [BYTE_W-1:0] DUP_REPS_RST = 8'd15;
  localparam logic [BYTE_W-1:0] FIN_REPS_RST = 8'd50;

  localparam logic [BYTE_W-1:0] SEQ_FIRST = 8'd1;

  typedef struct packed {
    logic [BYTE_W-1:0] rx_byte;
    logic              packet_start;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] seq_number;
    logic [BYTE_W-1:0] image_byte;
    logic [BYTE_W-1:0] repeat_count;
  } out_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] max_seq;
    logic [BYTE_W-1:0] new_ack_repeats;
    logic [BYTE_W-1:0] dup_ack_repeats;
    logic [BYTE_W-1:0] fin_repeats;
  } cfg_t;

endpackage

FILE: hdl/stop_wait_image_chunk_receiver.sv
// Top level: stop-and-wait receiver that turns packet bytes into acks and image bytes.
//
// Input channel (in_valid_i / in_ready_o / in_data_i) carries one received
// packet byte per item; packet_start marks the sequence byte of a packet.
// Output channel (out_valid_o / out_ready_i / out_data_o) carries at most one
// result per input item: an ack with its repeat count, an image byte, or the
// final image byte together with the finish repeat count.
// The APB port holds max_seq and the three repeat counts at 0x0, 0x4, 0x8, 0xC.
// Every byte is decided in the cycle it is accepted and its result lands in
// the output register, so throughput is 1 item per cycle while the output is
// not stalled; bytes that produce no result only update the receiver state.
// If the consumer stalls with a result waiting, in_ready_o drops until that
// result is taken; taking it and accepting the next byte can share a cycle.
// Reset restores the register defaults, expects sequence number 1, clears the
// packet and marker tracking and empties the output register.
module stop_wait_image_chunk_receiver #(
  parameter int unsigned PAYLOAD_BYTES = swicr_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  swicr_pkg::in_item_t          in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output swicr_pkg::out_item_t         out_data_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [swicr_pkg::ADDR_W-1:0] paddr,
  input  logic [swicr_pkg::DATA_W-1:0] pwdata,
  output logic [swicr_pkg::DATA_W-1:0] prdata,
  output logic                         pready
);

  localparam logic [swicr_pkg::POS_W-1:0] PosLimit = swicr_pkg::POS_W'(PAYLOAD_BYTES);

  swicr_pkg::cfg_t cfg;

  swicr_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Receiver state
  logic [swicr_pkg::BYTE_W-1:0] exp_seq_q, exp_seq_d;
  logic                         accepted_q, accepted_d;
  logic [swicr_pkg::POS_W-1:0]  pos_q, pos_d;
  logic                         last_ff_q, last_ff_d;
  logic                         closed_q, closed_d;

  // Output register
  logic                 out_valid_q, out_valid_d;
  swicr_pkg::out_item_t out_data_q;

  logic                         in_fire;
  logic                         res_valid;
  swicr_pkg::out_item_t         res;
  logic [swicr_pkg::BYTE_W-1:0] prev_seq;
  logic [swicr_pkg::BYTE_W:0]   next_seq;
  logic [swicr_pkg::BYTE_W-1:0] b;

  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign in_fire    = in_valid_i & in_ready_o;
  assign b          = in_data_i.rx_byte;

  // Previous and next sequence numbers
  assign prev_seq = (exp_seq_q == swicr_pkg::SEQ_FIRST) ? cfg.max_seq
                                                        : exp_seq_q - 8'd1;
  assign next_seq = {1'b0, exp_seq_q} + 9'd1;

  // Per-byte decision
  always_comb begin
    exp_seq_d  = exp_seq_q;
    accepted_d = accepted_q;
    pos_d      = pos_q;
    last_ff_d  = last_ff_q;
    closed_d   = closed_q;
    res_valid  = 1'b0;
    res        = '0;
    if (in_data_i.packet_start) begin
      closed_d = 1'b0;
      pos_d    = '0;
      if (b == exp_seq_q) begin
        accepted_d       = 1'b1;
        res_valid        = 1'b1;
        res.kind         = swicr_pkg::KIND_ACK;
        res.seq_number   = exp_seq_q;
        res.repeat_count = cfg.new_ack_repeats;
        exp_seq_d = (next_seq > {1'b0, cfg.max_seq}) ? swicr_pkg::SEQ_FIRST
                                                     : next_seq[swicr_pkg::BYTE_W-1:0];
      end else begin
        accepted_d = 1'b0;
        if (b == prev_seq) begin
          res_valid        = 1'b1;
          res.kind         = swicr_pkg::KIND_ACK;
          res.seq_number   = prev_seq;
          res.repeat_count = cfg.dup_ack_repeats;
        end
      end
    end else if (accepted_q && !closed_q && (pos_q < PosLimit)) begin
      pos_d          = pos_q + 6'd1;
      res_valid      = 1'b1;
      res.image_byte = b;
      if (last_ff_q && (b == swicr_pkg::MARK_LO)) begin
        // End of image: finish and restart the numbering
        exp_seq_d        = swicr_pkg::SEQ_FIRST;
        last_ff_d        = 1'b0;
        closed_d         = 1'b1;
        accepted_d       = 1'b0;
        res.kind         = swicr_pkg::KIND_FIN;
        res.repeat_count = cfg.fin_repeats;
      end else begin
        last_ff_d = (b == swicr_pkg::MARK_HI);
        res.kind  = swicr_pkg::KIND_IMG;
      end
    end
  end

  // Output valid: load on accept, drain on take
  always_comb begin
    if (in_fire) begin
      out_valid_d = res_valid;
    end else begin
      out_valid_d = out_valid_q & ~out_ready_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_seq_q   <= swicr_pkg::SEQ_FIRST;
      accepted_q  <= 1'b0;
      pos_q       <= '0;
      last_ff_q   <= 1'b0;
      closed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_fire) begin
        exp_seq_q  <= exp_seq_d;
        accepted_q <= accepted_d;
        pos_q      <= pos_d;
        last_ff_q  <= last_ff_d;
        closed_q   <= closed_d;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (in_fire && res_valid) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: hdl/swicr_regs.sv
// APB configuration registers of the image chunk receiver.
module swicr_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [swicr_pkg::ADDR_W-1:0]     paddr,
  input  logic [swicr_pkg::DATA_W-1:0]     pwdata,
  output logic [swicr_pkg::DATA_W-1:0]     prdata,
  output logic                             pready,
  output swicr_pkg::cfg_t                  cfg_o
);

  swicr_pkg::cfg_t cfg_q, cfg_d;
  logic [1:0]      reg_idx;
  logic            wr_en;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  // Write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        swicr_pkg::REG_MAX_SEQ:  cfg_d.max_seq         = pwdata[swicr_pkg::BYTE_W-1:0];
        swicr_pkg::REG_NEW_REPS: cfg_d.new_ack_repeats = pwdata[swicr_pkg::BYTE_W-1:0];
        swicr_pkg::REG_DUP_REPS: cfg_d.dup_ack_repeats = pwdata[swicr_pkg::BYTE_W-1:0];
        swicr_pkg::REG_FIN_REPS: cfg_d.fin_repeats     = pwdata[swicr_pkg::BYTE_W-1:0];
        default:                 cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_seq         <= swicr_pkg::MAX_SEQ_RST;
      cfg_q.new_ack_repeats <= swicr_pkg::NEW_REPS_RST;
      cfg_q.dup_ack_repeats <= swicr_pkg::DUP_REPS_RST;
      cfg_q.fin_repeats     <= swicr_pkg::FIN_REPS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read mux
  always_comb begin
    case (reg_idx)
      swicr_pkg::REG_MAX_SEQ:  prdata = {24'd0, cfg_q.max_seq};
      swicr_pkg::REG_NEW_REPS: prdata = {24'd0, cfg_q.new_ack_repeats};
      swicr_pkg::REG_DUP_REPS: prdata = {24'd0, cfg_q.dup_ack_repeats};
      swicr_pkg::REG_FIN_REPS: prdata = {24'd0, cfg_q.fin_repeats};
      default:                 prdata = '0;
    endcase
  end

endmodule

FILE: hdl/swicr_checker.sv
// Port-level checker for the image chunk receiver, bound to the top level.
`include "stop_wait_image_chunk_receiver_assert.svh"

module swicr_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input swicr_pkg::out_item_t         out_data_o,
  input logic                         pready
);

  // A waiting result holds until taken
  `SWICR_ASSERT(a_out_hold, (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)), "result changed while stalled")

  // A stalled output blocks new items
  `SWICR_ASSERT(a_backpressure, (out_valid_o && !out_ready_i) |-> !in_ready_o, "item taken while output stalled")

  // Only the three result kinds appear
  `SWICR_ASSERT(a_kind_legal, out_valid_o |-> (out_data_o.kind == swicr_pkg::KIND_ACK || out_data_o.kind == swicr_pkg::KIND_IMG || out_data_o.kind == swicr_pkg::KIND_FIN), "illegal result kind")

  // Image bytes carry no sequence number and no repeat count
  `SWICR_ASSERT(a_img_clean, (out_valid_o && out_data_o.kind == swicr_pkg::KIND_IMG) |-> (out_data_o.seq_number == 8'd0 && out_data_o.repeat_count == 8'd0), "image byte with ack fields")

  // The config port never inserts wait states
  `SWICR_ASSERT_ALWAYS(a_pready, pready, "pready low")

endmodule

bind stop_wait_image_chunk_receiver swicr_checker u_swicr_checker (.*);
